>>> design/rcd_pkg.sv
`timescale 1ns / 1ps

package rcd_pkg;

  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_RESYNC = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [7:0]  SYNC_FIRST      = 8'hFF;
  localparam logic [7:0]  SYNC_SECOND     = 8'hFE;
  localparam int unsigned PAYLOAD_LEN     = 10;
  localparam int unsigned POS_W           = 4;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
  localparam logic [15:0] AGE_MAX         = 16'hFFFF;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QUEUE_PTR_W     = 1;
  localparam int unsigned QUEUE_CNT_W     = 2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic               frame_done;
    logic               checksum_ok;
    logic signed [15:0] roll_cmd;
    logic signed [15:0] pitch_cmd;
    logic signed [15:0] yaw_cmd;
    logic signed [15:0] aux_cmd;
    logic [7:0]         throttle_cmd;
    logic [7:0]         button_bits;
    logic               link_valid;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_RESYNC = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_kind_t;

  // decoded request handed from the front to the back
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       is_sync1;
    logic       is_sync2;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'b001,
    PH_SYNC2   = 3'b010,
    PH_COLLECT = 3'b100
  } phase_t;

endpackage

>>> design/rcd_front.sv
`timescale 1ns / 1ps

module rcd_front (
  input  logic             push,
  output logic             full,
  input  rcd_pkg::in_item_t in_item,
  input  logic             q_full,
  output logic             q_push,
  output rcd_pkg::cmd_t    q_cmd
);

  assign full   = q_full;
  assign q_push = push & ~q_full;

  always_comb begin
    q_cmd.data     = in_item.data_byte;
    q_cmd.is_sync1 = (in_item.data_byte == rcd_pkg::SYNC_FIRST);
    q_cmd.is_sync2 = (in_item.data_byte == rcd_pkg::SYNC_SECOND);
    unique case (in_item.opcode)
      rcd_pkg::OP_BYTE:   q_cmd.kind = rcd_pkg::CMD_BYTE;
      rcd_pkg::OP_RESYNC: q_cmd.kind = rcd_pkg::CMD_RESYNC;
      rcd_pkg::OP_TICK:   q_cmd.kind = rcd_pkg::CMD_TICK;
      default:            q_cmd.kind = rcd_pkg::CMD_NOP;
    endcase
  end

endmodule

>>> design/rcd_cmd_queue.sv
`timescale 1ns / 1ps

module rcd_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  rcd_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd_en,
  output logic          q_empty,
  output rcd_pkg::cmd_t rd_cmd
);

  rcd_pkg::cmd_t                     mem_r [rcd_pkg::QUEUE_DEPTH];
  logic [rcd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rcd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rcd_pkg::QUEUE_CNT_W-1:0]   count_r, count_nxt;

  assign q_full  = (count_r == rcd_pkg::QUEUE_CNT_W'(rcd_pkg::QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign rd_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + 1'b1;
    rd_ptr_nxt = rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

>>> design/rcd_back.sv
`timescale 1ns / 1ps

module rcd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               q_empty,
  input  rcd_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output rcd_pkg::out_item_t out_item
);

  logic [15:0]               timeout_r;
  rcd_pkg::phase_t           phase_r, phase_nxt;
  logic [rcd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                xor_r, xor_nxt;
  logic [7:0]                store_r [rcd_pkg::PAYLOAD_LEN];
  logic                      store_we;
  logic [15:0]               sticks_r [4];
  logic [15:0]               sticks_nxt [4];
  logic [7:0]                throttle_r, throttle_nxt;
  logic [7:0]                buttons_r, buttons_nxt;
  logic [15:0]               age_r, age_nxt;
  logic                      done, ok;
  rcd_pkg::out_item_t        res;

  // result queue
  rcd_pkg::out_item_t              res_mem_r [rcd_pkg::QUEUE_DEPTH];
  logic [rcd_pkg::QUEUE_PTR_W-1:0] res_wr_ptr_r, res_rd_ptr_r;
  logic [rcd_pkg::QUEUE_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                            res_full, res_pop;

  assign res_full = (res_cnt_r == rcd_pkg::QUEUE_CNT_W'(rcd_pkg::QUEUE_DEPTH));
  assign empty    = (res_cnt_r == '0);
  assign res_pop  = pop & ~empty;
  assign out_item = res_mem_r[res_rd_ptr_r];
  // a slot freed by this cycle's pop may be refilled at once
  assign q_pop    = ~q_empty & (~res_full | res_pop);

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    xor_nxt      = xor_r;
    store_we     = 1'b0;
    sticks_nxt   = sticks_r;
    throttle_nxt = throttle_r;
    buttons_nxt  = buttons_r;
    age_nxt      = age_r;
    done         = 1'b0;
    ok           = 1'b0;
    if (q_pop) begin
      unique case (q_cmd.kind)
        rcd_pkg::CMD_BYTE: begin
          unique case (phase_r)
            rcd_pkg::PH_COLLECT: begin
              if (pos_r < rcd_pkg::POS_W'(rcd_pkg::PAYLOAD_LEN)) begin
                store_we = 1'b1;
                xor_nxt  = xor_r ^ q_cmd.data;
                pos_nxt  = pos_r + 1'b1;
              end else begin
                done = 1'b1;
                if (xor_r == q_cmd.data) begin
                  ok = 1'b1;
                  for (int k = 0; k < 4; k++) begin
                    sticks_nxt[k] = {store_r[2*k+1], store_r[2*k]};
                  end
                  throttle_nxt = store_r[8];
                  buttons_nxt  = store_r[9];
                  age_nxt      = '0;
                end
                phase_nxt = rcd_pkg::PH_SYNC1;
                pos_nxt   = '0;
                xor_nxt   = '0;
              end
            end
            rcd_pkg::PH_SYNC2: begin
              if (q_cmd.is_sync2) begin
                phase_nxt = rcd_pkg::PH_COLLECT;
                pos_nxt   = '0;
                xor_nxt   = '0;
              end else if (!q_cmd.is_sync1) begin
                phase_nxt = rcd_pkg::PH_SYNC1;
                pos_nxt   = '0;
                xor_nxt   = '0;
              end
            end
            default: begin
              if (q_cmd.is_sync1) begin
                phase_nxt = rcd_pkg::PH_SYNC2;
              end else begin
                phase_nxt = rcd_pkg::PH_SYNC1;
                pos_nxt   = '0;
                xor_nxt   = '0;
              end
            end
          endcase
        end
        rcd_pkg::CMD_RESYNC: begin
          phase_nxt = rcd_pkg::PH_SYNC1;
          pos_nxt   = '0;
          xor_nxt   = '0;
        end
        rcd_pkg::CMD_TICK: begin
          if (age_r != rcd_pkg::AGE_MAX) begin
            age_nxt = age_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.frame_done   = done;
    res.checksum_ok  = ok;
    res.roll_cmd     = sticks_nxt[0];
    res.pitch_cmd    = sticks_nxt[1];
    res.yaw_cmd      = sticks_nxt[2];
    res.aux_cmd      = sticks_nxt[3];
    res.throttle_cmd = throttle_nxt;
    res.button_bits  = buttons_nxt;
    res.link_valid   = (age_nxt < timeout_r);
  end

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (q_pop && !res_pop) begin
      res_cnt_nxt = res_cnt_r + 1'b1;
    end else if (!q_pop && res_pop) begin
      res_cnt_nxt = res_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= rcd_pkg::TIMEOUT_RESET;
      phase_r      <= rcd_pkg::PH_SYNC1;
      pos_r        <= '0;
      xor_r        <= '0;
      for (int k = 0; k < 4; k++) begin
        sticks_r[k] <= '0;
      end
      throttle_r   <= '0;
      buttons_r    <= '0;
      age_r        <= '0;
      res_wr_ptr_r <= '0;
      res_rd_ptr_r <= '0;
      res_cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      xor_r      <= xor_nxt;
      sticks_r   <= sticks_nxt;
      throttle_r <= throttle_nxt;
      buttons_r  <= buttons_nxt;
      age_r      <= age_nxt;
      if (q_pop) begin
        res_wr_ptr_r <= res_wr_ptr_r + 1'b1;
      end
      if (res_pop) begin
        res_rd_ptr_r <= res_rd_ptr_r + 1'b1;
      end
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[pos_r] <= q_cmd.data;
    end
    if (q_pop) begin
      res_mem_r[res_wr_ptr_r] <= res;
    end
  end

endmodule

>>> design/rc_frame_deframer.sv
`timescale 1ns / 1ps
// a request accepted at an edge is written into the command queue; the back end executes it when
//   the result queue has room and registers its result there, from where it can be popped
// throughput: one request per cycle unless the result queue is full and not popped
// two-entry queues sit between front and back and in front of the result ports
// reset: synchronous active-low rst_n empties both queues, returns the parser to sync
//   search, clears held values and age, and loads the timeout with 100 ms

module rc_frame_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  rcd_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output rcd_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  logic          q_full, q_push, q_empty, q_pop;
  rcd_pkg::cmd_t q_wr_cmd, q_rd_cmd;

  rcd_front u_front (
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd)
  );

  rcd_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_cmd  (q_wr_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_cmd  (q_rd_cmd)
  );

  rcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_cmd       (q_rd_cmd),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item)
  );

endmodule

>>> tb/rc_frame_deframer_tb.sv
`timescale 1ns / 1ps

module rc_frame_deframer_tb;

  localparam logic [1:0]  OP_IGNORED  = 2'd3;
  localparam int          STALL_LIMIT = 2000;
  localparam int          MAX_REPORTS = 10;
  // payload bytes 0..9, byte 0 in the low bits: sticks 0x8000, 0x7fff, 0xffff, 0x0001
  localparam logic [79:0] EXTREME_PAYLOAD = 80'h00FF_0001_FFFF_7FFF_8000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  rcd_pkg::in_item_t  in_item = '0;
  logic               empty;
  logic               pop = 1'b0;
  rcd_pkg::out_item_t out_item;
  logic               cfg_wr_en = 1'b0;
  logic [15:0]        cfg_wr_data = '0;

  rc_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // parser state as the block should hold it
  rcd_pkg::phase_t hunt_phase = rcd_pkg::PH_SYNC1;
  logic [3:0]  pos = '0;
  logic [7:0]  run_xor = '0;
  logic [7:0]  payload [rcd_pkg::PAYLOAD_LEN];
  logic [15:0] stick [4] = '{default: '0};
  logic [7:0]  throttle = '0;
  logic [7:0]  buttons = '0;
  logic [15:0] age_ms = '0;
  logic [15:0] link_limit = rcd_pkg::TIMEOUT_RESET;

  rcd_pkg::in_item_t  byte_stream [$];
  rcd_pkg::out_item_t expected_reports [$];
  rcd_pkg::out_item_t want;

  bit idling = 1'b1;
  int send_hold = 0;
  int pop_hold = 0;
  int quiet_cycles = 0;
  int queued = 0;
  int sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int good_frames = 0;
  int bad_frames = 0;

  function automatic void restart_hunt();
    hunt_phase = rcd_pkg::PH_SYNC1;
    pos = '0;
    run_xor = '0;
  endfunction

  function automatic rcd_pkg::out_item_t parse_step(input rcd_pkg::in_item_t it);
    rcd_pkg::out_item_t r;
    r = '0;
    case (it.opcode)
      rcd_pkg::OP_BYTE: begin
        if (hunt_phase == rcd_pkg::PH_COLLECT) begin
          if (pos < rcd_pkg::PAYLOAD_LEN) begin
            payload[pos] = it.data_byte;
            run_xor = run_xor ^ it.data_byte;
            pos = pos + 1'b1;
          end else begin
            r.frame_done = 1'b1;
            if (run_xor == it.data_byte) begin
              r.checksum_ok = 1'b1;
              for (int k = 0; k < 4; k++) stick[k] = {payload[2*k+1], payload[2*k]};
              throttle = payload[8];
              buttons = payload[9];
              age_ms = '0;
              good_frames++;
            end else begin
              bad_frames++;
            end
            restart_hunt();
          end
        end else if (hunt_phase == rcd_pkg::PH_SYNC2) begin
          if (it.data_byte == rcd_pkg::SYNC_SECOND) begin
            hunt_phase = rcd_pkg::PH_COLLECT;
            pos = '0;
            run_xor = '0;
          end else if (it.data_byte != rcd_pkg::SYNC_FIRST) begin
            restart_hunt();
          end
        end else if (it.data_byte == rcd_pkg::SYNC_FIRST) begin
          hunt_phase = rcd_pkg::PH_SYNC2;
        end else begin
          restart_hunt();
        end
      end
      rcd_pkg::OP_RESYNC: restart_hunt();
      rcd_pkg::OP_TICK: if (age_ms != rcd_pkg::AGE_MAX) age_ms = age_ms + 1'b1;
      default: ;
    endcase
    r.roll_cmd = stick[0];
    r.pitch_cmd = stick[1];
    r.yaw_cmd = stick[2];
    r.aux_cmd = stick[3];
    r.throttle_cmd = throttle;
    r.button_bits = buttons;
    r.link_valid = (age_ms < link_limit);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] got);
    if (exp_val !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d %s: expected %h, got %h", results_seen, name, exp_val, got);
    end
  endtask

  // sender: one request held on the port until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      send_hold <= 0;
    end else begin
      if (push && !full) begin
        expected_reports.push_back(parse_step(in_item));
        sent++;
      end
      if (!push || !full) begin
        if (send_hold > 0) begin
          push <= 1'b0;
          send_hold <= send_hold - 1;
        end else if (idling && $urandom_range(0, 9) == 0) begin
          push <= 1'b0;
          send_hold <= $urandom_range(0, 9);
        end else if (byte_stream.size() > 0) begin
          in_item <= byte_stream.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: checks every result taken against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      pop_hold <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d with no request waiting: %p", results_seen, out_item);
        end else begin
          want = expected_reports.pop_front();
          check_field("frame_done", want.frame_done, out_item.frame_done);
          check_field("checksum_ok", want.checksum_ok, out_item.checksum_ok);
          check_field("roll_cmd", want.roll_cmd, out_item.roll_cmd);
          check_field("pitch_cmd", want.pitch_cmd, out_item.pitch_cmd);
          check_field("yaw_cmd", want.yaw_cmd, out_item.yaw_cmd);
          check_field("aux_cmd", want.aux_cmd, out_item.aux_cmd);
          check_field("throttle_cmd", want.throttle_cmd, out_item.throttle_cmd);
          check_field("button_bits", want.button_bits, out_item.button_bits);
          check_field("link_valid", want.link_valid, out_item.link_valid);
        end
        results_seen++;
      end
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold <= pop_hold - 1;
      end else if (idling && $urandom_range(0, 11) == 0) begin
        pop <= 1'b0;
        pop_hold <= $urandom_range(0, 9);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
      $display("rc_frame_deframer_tb: done, errors");
      $finish;
    end
  end

  task automatic add(input logic [1:0] op, input logic [7:0] data);
    rcd_pkg::in_item_t it;
    it.opcode = op;
    it.data_byte = data;
    byte_stream.push_back(it);
    queued++;
  endtask

  task automatic add_ticks(input int n);
    for (int i = 0; i < n; i++) add(rcd_pkg::OP_TICK, 8'($urandom));
  endtask

  // cut_at in 0..9 drops the frame with a line error before that payload byte
  task automatic add_frame(input bit corrupt, input int cut_at);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    if ($urandom_range(0, 3) == 0) add(rcd_pkg::OP_BYTE, rcd_pkg::SYNC_FIRST);
    add(rcd_pkg::OP_BYTE, rcd_pkg::SYNC_FIRST);
    add(rcd_pkg::OP_BYTE, rcd_pkg::SYNC_SECOND);
    for (int i = 0; i < rcd_pkg::PAYLOAD_LEN; i++) begin
      if (i == cut_at) begin
        add(rcd_pkg::OP_RESYNC, 8'($urandom));
        return;
      end
      b = 8'($urandom);
      add(rcd_pkg::OP_BYTE, b);
      sum = sum ^ b;
      case ($urandom_range(0, 15))
        0: add(rcd_pkg::OP_TICK, 8'($urandom));
        1: add(OP_IGNORED, 8'($urandom));
        default: ;
      endcase
    end
    add(rcd_pkg::OP_BYTE, corrupt ? 8'(sum ^ $urandom_range(1, 255)) : sum);
  endtask

  task automatic add_random(input int n);
    int first;
    int pick;
    first = queued;
    while (queued - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        add_frame($urandom_range(0, 3) == 0,
                  ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 9)) : -1);
      else if (pick < 70)
        add_ticks($urandom_range(1, 12));
      else if (pick < 80)
        add(rcd_pkg::OP_BYTE, 8'($urandom));
      else if (pick < 87)
        add(rcd_pkg::OP_RESYNC, 8'($urandom));
      else if (pick < 92)
        add(OP_IGNORED, 8'($urandom));
      else begin
        add(rcd_pkg::OP_BYTE, rcd_pkg::SYNC_FIRST);
        add(rcd_pkg::OP_BYTE, 8'($urandom));
      end
    end
  endtask

  // holds the test sequence until every queued request is sent and every prediction is matched
  task automatic wait_drain();
    do @(negedge clk);
    while (byte_stream.size() != 0 || push || expected_reports.size() != 0);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    link_limit = value;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] sum;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add(OP_IGNORED, 8'hFF);
    add(rcd_pkg::OP_BYTE, 8'h00);
    add(rcd_pkg::OP_BYTE, rcd_pkg::SYNC_FIRST);
    add(rcd_pkg::OP_BYTE, rcd_pkg::SYNC_FIRST);
    add(rcd_pkg::OP_BYTE, rcd_pkg::SYNC_SECOND);
    sum = '0;
    for (int i = 0; i < rcd_pkg::PAYLOAD_LEN; i++) begin
      add(rcd_pkg::OP_BYTE, EXTREME_PAYLOAD[8*i +: 8]);
      sum = sum ^ EXTREME_PAYLOAD[8*i +: 8];
    end
    add(rcd_pkg::OP_TICK, 8'h00);
    add(rcd_pkg::OP_BYTE, sum);
    // wrong second sync byte, then a line error in the middle of a frame
    add(rcd_pkg::OP_BYTE, rcd_pkg::SYNC_FIRST);
    add(rcd_pkg::OP_BYTE, 8'h55);
    add(rcd_pkg::OP_BYTE, rcd_pkg::SYNC_FIRST);
    add(rcd_pkg::OP_BYTE, rcd_pkg::SYNC_SECOND);
    add(rcd_pkg::OP_BYTE, 8'h12);
    add(rcd_pkg::OP_RESYNC, 8'hFF);

    add_frame(1'b1, -1);
    add_random(150);
    add_ticks(110);
    add_frame(1'b0, -1);
    wait_drain();

    write_timeout(16'd0);
    add_random(100);
    wait_drain();

    write_timeout(16'd1);
    add_random(100);
    wait_drain();

    write_timeout(rcd_pkg::AGE_MAX);
    add_ticks(20);
    add_frame(1'b0, -1);
    add_ticks(3);
    wait_drain();

    write_timeout(16'($urandom_range(2, 40)));
    add_random(130);
    wait_drain();

    idling = 1'b0;
    write_timeout(16'($urandom_range(3, 12)));
    add_random(130);
    wait_drain();
    repeat (6) @(posedge clk);

    $display("run: %0d requests sent, %0d results checked, %0d good and %0d bad frames",
             sent, results_seen, good_frames, bad_frames);
    $display("timeouts used: reset value, 0, 1, 65535, two mid values;"
             , " %0d mismatches", mismatches);
    if (mismatches == 0)
      $display("rc_frame_deframer_tb: done, clean");
    else
      $display("rc_frame_deframer_tb: done, errors");
    $finish;
  end

endmodule
